// ===== hdl/dfs_pkg.sv =====
package dfs_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int VERTEX_W     = 3;
  localparam int VSLOTS       = 1 << VERTEX_W;
  localparam int ACTIVE_MAX   = (MAX_VERTICES < VSLOTS) ? MAX_VERTICES : VSLOTS;
  localparam int COUNT_W      = 4;
  localparam int SP_W         = VERTEX_W + 1;

  localparam logic [COUNT_W-1:0] VCOUNT_RESET = COUNT_W'(8);

  typedef logic [VERTEX_W-1:0] vertex_t;
  typedef logic [COUNT_W-1:0]  vcount_t;
  typedef logic [VSLOTS-1:0]   vmask_t;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_RUN   = 2'd2
  } func_t;

  typedef struct packed {
    func_t   func;
    vertex_t vertex_a;
    vertex_t vertex_b;
  } cmd_item_t;

  typedef struct packed {
    vertex_t visited_vertex;
    logic    last_visit;
  } visit_item_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic start;
    logic push;
    logic pop;
    logic emit;
    logic last;
  } dp_ctl_t;

  typedef struct packed {
    logic start_ok;
    logic found;
    logic last_pop;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/dfs_dp.sv =====
module dfs_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  dfs_pkg::vcount_t   cfg_data,
  input  dfs_pkg::cmd_item_t cmd,
  input  dfs_pkg::dp_ctl_t   ctl,
  output dfs_pkg::dp_stat_t  stat,
  input  logic               visit_ready,
  output logic               visit_valid,
  output dfs_pkg::visit_item_t visit
);
  import dfs_pkg::*;

  vcount_t         vertex_count;
  vcount_t         act_n;
  vmask_t          range_mask;
  vmask_t          rows [VSLOTS];
  vmask_t          visited;
  vertex_t         stack [VSLOTS];
  logic [SP_W-1:0] sp;
  vertex_t         pending;
  vertex_t         top;
  vmask_t          cand;
  vertex_t         next_v;
  logic            a_ok;
  logic            b_ok;

  function automatic vertex_t lowest_bit(input vmask_t m);
    vertex_t r;
    r = '0;
    for (int i = VSLOTS - 1; i >= 0; i--) begin
      if (m[i]) r = VERTEX_W'(i);
    end
    return r;
  endfunction

  always_comb begin
    act_n = (vertex_count > COUNT_W'(ACTIVE_MAX)) ? COUNT_W'(ACTIVE_MAX) : vertex_count;
    for (int i = 0; i < VSLOTS; i++) begin
      range_mask[i] = (COUNT_W'(i) < act_n);
    end
    a_ok   = (COUNT_W'(cmd.vertex_a) < act_n);
    b_ok   = (COUNT_W'(cmd.vertex_b) < act_n);
    top    = stack[VERTEX_W'(sp - SP_W'(1))];
    cand   = rows[top] & range_mask & ~visited;
    next_v = lowest_bit(cand);
  end

  assign stat.start_ok = a_ok;
  assign stat.found    = |cand;
  assign stat.last_pop = (sp == SP_W'(1));
  assign stat.out_free = !visit_valid || visit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < VSLOTS; i++) begin
        rows[i] <= '0;
      end
    end else if (ctl.add && a_ok && b_ok) begin
      for (int i = 0; i < VSLOTS; i++) begin
        rows[i] <= rows[i]
                 | (vmask_t'(cmd.vertex_a == VERTEX_W'(i)) << cmd.vertex_b)
                 | (vmask_t'(cmd.vertex_b == VERTEX_W'(i)) << cmd.vertex_a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      sp      <= '0;
    end else if (ctl.start) begin
      visited <= vmask_t'(1) << cmd.vertex_a;
      sp      <= SP_W'(1);
    end else if (ctl.push) begin
      visited <= visited | (vmask_t'(1) << next_v);
      sp      <= sp + SP_W'(1);
    end else if (ctl.pop) begin
      sp      <= sp - SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      stack[0] <= cmd.vertex_a;
      pending  <= cmd.vertex_a;
    end else if (ctl.push) begin
      stack[VERTEX_W'(sp)] <= next_v;
      pending              <= next_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visit_valid <= 1'b0;
    end else if (ctl.emit) begin
      visit_valid <= 1'b1;
    end else if (visit_ready) begin
      visit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      visit.visited_vertex <= pending;
      visit.last_visit     <= ctl.last;
    end
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(VSLOTS))
    else $error("stack pointer beyond capacity");
  a_stack_visited: assert property (@(posedge clk) disable iff (rst)
    $countones(visited) >= int'(sp))
    else $error("stack holds more vertices than visited");
  a_start_onehot: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> $onehot(visited) && sp == SP_W'(1))
    else $error("run start left bad walk state");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> stat.out_free)
    else $error("result emitted over a held result");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> $countones(visited) == $countones($past(visited)) + 1)
    else $error("push did not mark a new vertex");
`endif

endmodule

// ===== hdl/dfs_ctrl.sv =====
module dfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  dfs_pkg::func_t     func,
  input  dfs_pkg::dp_stat_t  stat,
  output dfs_pkg::dp_ctl_t   ctl
);
  import dfs_pkg::*;

  typedef enum logic {
    IDLE,
    WALK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd_ready  = (state == IDLE);
    ctl        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (cmd_valid) begin
          case (func)
            FUNC_CLEAR: ctl.clear = 1'b1;
            FUNC_ADD:   ctl.add   = 1'b1;
            FUNC_RUN: begin
              ctl.start = stat.start_ok;
              if (stat.start_ok) state_next = WALK;
            end
            default: ;
          endcase
        end
      end
      WALK: begin
        if (stat.found) begin
          if (stat.out_free) begin
            ctl.push = 1'b1;
            ctl.emit = 1'b1;
          end
        end else if (!stat.last_pop) begin
          ctl.pop = 1'b1;
        end else if (stat.out_free) begin
          ctl.pop    = 1'b1;
          ctl.emit   = 1'b1;
          ctl.last   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_walk_no_cmd: assert property (@(posedge clk) disable iff (rst)
    (ctl.push || ctl.pop) |-> !ctl.start && !ctl.add && !ctl.clear)
    else $error("walk step overlaps a command");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    ctl.last |=> state == IDLE)
    else $error("final result did not end the walk");
  a_start_walks: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> state == WALK)
    else $error("run start did not enter walk");
`endif

endmodule

// ===== hdl/dfs_adjacency_matrix_order.sv =====
// Depth-first visit order over an undirected graph of up to 8 vertices.
// Command channel (cmd_valid/cmd_ready/cmd): clear the matrix, add an edge
// between vertex_a and vertex_b, or run a walk from vertex_a. Clear and
// add-edge return nothing; out-of-range edges are dropped.
// Result channel (visit_valid/visit_ready/visit): one item per visited
// vertex in order, the final one with last_visit set.
// Config channel (cfg_valid/cfg_ready/cfg_data) sets vertex_count; it is
// always ready. The user must see that it is written only while no run is
// in flight; the block does not enforce this. A run holds the command
// channel while it walks, each push or pop of the vertex stack after a
// priority encode over the top vertex's masked adjacency row. The first
// result is the start vertex. A run from a start vertex at or above the
// vertex count returns nothing.
// Each result waits in an output register; while the receiver stalls the
// walk holds at its next result-producing step. A new command is taken
// while the last result of a run still waits.
// Reset clears the matrix, the visited set and the stack, and sets the
// vertex count to 8.
module dfs_adjacency_matrix_order (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  dfs_pkg::cmd_item_t   cmd,
  output logic                 visit_valid,
  input  logic                 visit_ready,
  output dfs_pkg::visit_item_t visit,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  dfs_pkg::vcount_t     cfg_data
);
  import dfs_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  dfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .func      (cmd.func),
    .stat      (stat),
    .ctl       (ctl)
  );

  dfs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .ctl         (ctl),
    .stat        (stat),
    .visit_ready (visit_ready),
    .visit_valid (visit_valid),
    .visit       (visit)
  );

endmodule

// ===== sim/dfs_adjacency_matrix_order_tb.sv =====
module dfs_adjacency_matrix_order_tb;
  import dfs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int CHECK_WALK  = -1;
  localparam int PHASE_ITEMS = 86;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cmd_item_t c;
    vcount_t   cfg_val;
    int        typed_n;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  cmd_item_t   cmd = '0;
  logic        visit_valid;
  logic        visit_ready = 1'b0;
  visit_item_t visit;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  vcount_t     cfg_data = '0;

  vmask_t      adj_rows [VSLOTS];
  vcount_t     vcount_now = VCOUNT_RESET;
  visit_item_t visits_due [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycles = 0;

  dfs_adjacency_matrix_order DUT (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .visit_valid (visit_valid),
    .visit_ready (visit_ready),
    .visit       (visit),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    foreach (adj_rows[i]) adj_rows[i] = '0;
  end

  function automatic int active_vertices();
    return (int'(vcount_now) > ACTIVE_MAX) ? ACTIVE_MAX : int'(vcount_now);
  endfunction

  function automatic void mirror_command(input cmd_item_t c, output visit_item_t walk [$]);
    int      n;
    int      sp;
    int      nxt;
    vmask_t  in_use;
    vmask_t  seen;
    vmask_t  cand;
    vertex_t stk [VSLOTS];
    walk = {};
    n = active_vertices();
    in_use = (n >= VSLOTS) ? '1 : vmask_t'((1 << n) - 1);
    case (c.func)
      FUNC_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
      FUNC_ADD: begin
        if (c.vertex_a < n && c.vertex_b < n) begin
          adj_rows[c.vertex_a][c.vertex_b] = 1'b1;
          adj_rows[c.vertex_b][c.vertex_a] = 1'b1;
        end
      end
      FUNC_RUN: begin
        if (c.vertex_a < n) begin
          seen = vmask_t'(1) << c.vertex_a;
          stk[0] = c.vertex_a;
          sp = 1;
          walk.push_back('{visited_vertex: c.vertex_a, last_visit: 1'b0});
          while (sp > 0) begin
            cand = adj_rows[stk[sp-1]] & in_use & ~seen;
            if (cand == '0) begin
              sp--;
            end else begin
              nxt = 0;
              while (!cand[nxt]) nxt++;
              seen[nxt] = 1'b1;
              stk[sp] = vertex_t'(nxt);
              sp++;
              walk.push_back('{visited_vertex: vertex_t'(nxt), last_visit: 1'b0});
            end
          end
          walk[walk.size()-1].last_visit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic step_t cmd_row(func_t f, vertex_t a, vertex_t b, int typed_n);
    step_t s;
    s.kind = ROW_CMD;
    s.c = '{func: f, vertex_a: a, vertex_b: b};
    s.cfg_val = '0;
    s.typed_n = typed_n;
    return s;
  endfunction

  function automatic step_t cfg_row(vcount_t v);
    step_t s;
    s.kind = ROW_CFG;
    s.c = '0;
    s.cfg_val = v;
    s.typed_n = 0;
    return s;
  endfunction

  task automatic issue(cmd_item_t c, int typed_n);
    visit_item_t walk [$];
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    mirror_command(c, walk);
    if (typed_n != CHECK_WALK) begin
      walk = {};
      if (typed_n == 1) walk.push_back('{visited_vertex: c.vertex_a, last_visit: 1'b1});
    end
    foreach (walk[i]) visits_due.push_back(walk[i]);
  endtask

  task automatic set_vertex_count(vcount_t v);
    cmd_valid <= 1'b0;
    while (visits_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vcount_now = v;
  endtask

  always @(posedge clk) begin : visit_check
    visit_item_t want;
    visit_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && visit_valid && visit_ready) begin
      if (visits_due.size() == 0) begin
        errors++;
        $display("%0t: expected no visit, got vertex %0d last %0b",
                 $time, visit.visited_vertex, visit.last_visit);
      end else begin
        want = visits_due.pop_front();
        if (visit.visited_vertex !== want.visited_vertex) begin
          errors++;
          $display("%0t: visited_vertex expected %0d, got %0d",
                   $time, want.visited_vertex, visit.visited_vertex);
        end
        if (visit.last_visit !== want.last_visit) begin
          errors++;
          $display("%0t: last_visit expected %0b, got %0b",
                   $time, want.last_visit, visit.last_visit);
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("dfs_adjacency_matrix_order: mismatch");
    $finish;
  end

  initial begin
    step_t     plan [$];
    cmd_item_t c;
    int        n;
    int        counted;
    int        pick;

    plan = {
      cmd_row(FUNC_RUN, 3'd0, 3'd0, 1),
      cmd_row(FUNC_RUN, 3'd7, 3'd7, 1),
      cmd_row(func_t'(2'd3), 3'd7, 3'd7, 0),
      cmd_row(FUNC_ADD, 3'd0, 3'd7, 0),
      cmd_row(FUNC_ADD, 3'd7, 3'd7, 0),
      cmd_row(FUNC_ADD, 3'd1, 3'd0, 0),
      cmd_row(FUNC_ADD, 3'd2, 3'd1, 0),
      cmd_row(FUNC_ADD, 3'd6, 3'd3, 0),
      cmd_row(FUNC_ADD, 3'd3, 3'd1, 0),
      cmd_row(FUNC_ADD, 3'd4, 3'd2, 0),
      cmd_row(FUNC_ADD, 3'd5, 3'd6, 0),
      cmd_row(FUNC_RUN, 3'd0, 3'd5, CHECK_WALK),
      cmd_row(FUNC_RUN, 3'd7, 3'd0, CHECK_WALK),
      cmd_row(FUNC_RUN, 3'd5, 3'd0, CHECK_WALK),
      cfg_row(4'd4),
      cmd_row(FUNC_ADD, 3'd4, 3'd1, 0),
      cmd_row(FUNC_RUN, 3'd4, 3'd0, 0),
      cmd_row(FUNC_RUN, 3'd1, 3'd0, CHECK_WALK),
      cfg_row(4'd1),
      cmd_row(FUNC_RUN, 3'd0, 3'd0, 1),
      cfg_row(4'd0),
      cmd_row(FUNC_RUN, 3'd0, 3'd0, 0),
      cfg_row(4'd15),
      cmd_row(FUNC_RUN, 3'd3, 3'd7, CHECK_WALK),
      cmd_row(FUNC_CLEAR, 3'd5, 3'd5, 0),
      cmd_row(FUNC_RUN, 3'd6, 3'd0, 1),
      cfg_row(4'd8)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_vertex_count(plan[i].cfg_val);
      else issue(plan[i].c, plan[i].typed_n);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(9) < 4) begin
          pick = $urandom_range(15);
          if (pick < 2) set_vertex_count(vcount_t'($urandom_range(15)));
          else set_vertex_count(vcount_t'($urandom_range(1, 8)));
        end
        n = active_vertices();

        if ($urandom_range(9) < 7) begin
          c.func = FUNC_CLEAR;
          c.vertex_a = vertex_t'($urandom);
          c.vertex_b = vertex_t'($urandom);
          issue(c, CHECK_WALK);
          counted++;
        end

        repeat ($urandom_range(2 * n)) begin
          c.func = FUNC_ADD;
          if ($urandom_range(99) < 85) begin
            c.vertex_a = vertex_t'($urandom_range(n - 1));
            c.vertex_b = vertex_t'($urandom_range(n - 1));
          end else begin
            c.vertex_a = vertex_t'($urandom);
            c.vertex_b = vertex_t'($urandom);
          end
          issue(c, CHECK_WALK);
          if (c.vertex_a < n && c.vertex_b < n) counted++;
        end

        repeat ($urandom_range(1, 3)) begin
          c.func = FUNC_RUN;
          c.vertex_a = (n > 0) ? vertex_t'($urandom_range(n - 1)) : vertex_t'($urandom);
          c.vertex_b = vertex_t'($urandom);
          issue(c, CHECK_WALK);
          if (c.vertex_a < n) counted++;
        end

        // noise: unused code or a run from anywhere
        if ($urandom_range(99) < 15) begin
          c.func = func_t'(2'($urandom_range(2, 3)));
          c.vertex_a = vertex_t'($urandom);
          c.vertex_b = vertex_t'($urandom);
          issue(c, CHECK_WALK);
        end
      end
    end

    cmd_valid <= 1'b0;
    while (visits_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("dfs_adjacency_matrix_order: match");
    end else begin
      $display("dfs_adjacency_matrix_order: mismatch");
    end
    $finish;
  end

endmodule
